>>> rtl/cau_pkg.sv
// Shared types and codes of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_MAG = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // restoring steps: one overflow bit plus 32 quotient bits; 32 root digits
  localparam int QUO_STEPS  = 33;
  localparam int ROOT_STEPS = 32;

  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_MAG,
    KIND_NOP
  } kind_t;

  // item handed from the front end to the back end
  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] p_rr;   // lr*rr
    logic signed [63:0] p_ii;   // li*ri
    logic signed [63:0] p_ir;   // li*rr
    logic signed [63:0] p_ri;   // lr*ri
    logic signed [63:0] s_x;    // square of real (left for magnitude, right otherwise)
    logic signed [63:0] s_y;    // square of imag
    logic signed [32:0] as_re;  // add/sub sums
    logic signed [32:0] as_im;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/cau_front.sv
// Front end: accepts items, decodes the action and forms all products.
`default_nettype none
module cau_front import cau_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         action,
  input  wire  signed [31:0] left_real,
  input  wire  signed [31:0] left_imag,
  input  wire  signed [31:0] right_real,
  input  wire  signed [31:0] right_imag,
  output logic               push_valid,
  input  wire                push_ready,
  output entry_t             push_entry
);

  logic               f1_v_r;
  kind_t              f1_kind_r;
  logic signed [31:0] lr_r, li_r, rr_r, ri_r;
  logic               f2_v_r;
  entry_t             f2_entry_r;
  logic               f2_ld;
  kind_t              kind_dec;
  logic signed [31:0] sq_a, sq_b;

  assign f2_ld    = !f2_v_r || push_ready;
  assign in_ready = !f1_v_r || f2_ld;

  always_comb begin
    case (action)
      ACT_ADD: kind_dec = KIND_ADD;
      ACT_SUB: kind_dec = KIND_SUB;
      ACT_MUL: kind_dec = KIND_MUL;
      ACT_DIV: kind_dec = KIND_DIV;
      ACT_MAG: kind_dec = KIND_MAG;
      default: kind_dec = KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (in_ready) begin
      f1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f1_kind_r <= kind_dec;
      lr_r      <= left_real;
      li_r      <= left_imag;
      rr_r      <= right_real;
      ri_r      <= right_imag;
    end
  end

  // magnitude squares the left operand, divide the right one
  assign sq_a = (f1_kind_r == KIND_MAG) ? lr_r : rr_r;
  assign sq_b = (f1_kind_r == KIND_MAG) ? li_r : ri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_ld) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_ld && f1_v_r) begin
      f2_entry_r.kind  <= f1_kind_r;
      f2_entry_r.p_rr  <= 64'(lr_r) * 64'(rr_r);
      f2_entry_r.p_ii  <= 64'(li_r) * 64'(ri_r);
      f2_entry_r.p_ir  <= 64'(li_r) * 64'(rr_r);
      f2_entry_r.p_ri  <= 64'(lr_r) * 64'(ri_r);
      f2_entry_r.s_x   <= 64'(sq_a) * 64'(sq_a);
      f2_entry_r.s_y   <= 64'(sq_b) * 64'(sq_b);
      f2_entry_r.as_re <= (f1_kind_r == KIND_SUB) ? 33'(lr_r) - 33'(rr_r)
                                                  : 33'(lr_r) + 33'(rr_r);
      f2_entry_r.as_im <= (f1_kind_r == KIND_SUB) ? 33'(li_r) - 33'(ri_r)
                                                  : 33'(li_r) + 33'(ri_r);
    end
  end

  assign push_valid = f2_v_r;
  assign push_entry = f2_entry_r;

endmodule
`default_nettype wire

>>> rtl/cau_fifo.sv
// Short queue between the front end and the back end.
`default_nettype none
module cau_fifo import cau_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire    clk,
  input  wire    rst_n,
  input  wire    wr_valid,
  output logic   wr_ready,
  input  entry_t wr_data,
  output logic   rd_valid,
  input  wire    rd_ready,
  output entry_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count lost a write");
  a_cnt_dn: assert property (@(posedge clk) disable iff (!rst_n)
    do_rd && !do_wr |=> cnt_r == $past(cnt_r) - 1'b1) else $error("count lost a read");

endmodule
`default_nettype wire

>>> rtl/cau_back.sv
// Back end: combines products, runs the divide and root pipelines, saturates.
`default_nettype none
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          q_valid,
  output logic         q_ready,
  input  entry_t       q_data,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [31:0]  out_real,
  output logic [31:0]  out_imag,
  output logic [1:0]   status
);

  // remainder must hold den << 32 as well as |num| << FRAC_BITS
  localparam int RW = (64 + FRAC_BITS > 96) ? 64 + FRAC_BITS : 96;
  localparam int NS = QUO_STEPS;

  function automatic logic [32:0] clip65(input logic signed [64:0] v);
    logic all1, all0;
    all1 = &v[64:31];
    all0 = ~|v[64:31];
    if (all1 || all0) return {1'b0, v[31:0]};
    return {1'b1, v[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
  endfunction

  function automatic logic [32:0] quo_out(input logic neg, input logic [32:0] q);
    logic ovf;
    if (neg) begin
      ovf = q[32] || (q[31:0] > 32'h8000_0000);
      return ovf ? {1'b1, 32'h8000_0000} : {1'b0, 32'd0 - q[31:0]};
    end
    ovf = q[32] || q[31];
    return ovf ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q[31:0]};
  endfunction

  logic adv;
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  // B0: sums of products
  logic               b0_v_r;
  kind_t              b0_kind_r;
  logic signed [64:0] b0_nre_r, b0_nim_r;
  logic [63:0]        b0_den_r;
  logic signed [32:0] b0_as_re_r, b0_as_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      b0_kind_r  <= q_data.kind;
      b0_nre_r   <= (q_data.kind == KIND_MUL) ? 65'(q_data.p_rr) - 65'(q_data.p_ii)
                                              : 65'(q_data.p_rr) + 65'(q_data.p_ii);
      b0_nim_r   <= (q_data.kind == KIND_MUL) ? 65'(q_data.p_ir) + 65'(q_data.p_ri)
                                              : 65'(q_data.p_ir) - 65'(q_data.p_ri);
      b0_den_r   <= $unsigned(q_data.s_x) + $unsigned(q_data.s_y);
      b0_as_re_r <= q_data.as_re;
      b0_as_im_r <= q_data.as_im;
    end
  end

  // stage arrays: index 0 is the prep stage, 1..NS the restoring steps
  logic          st_v_r    [0:NS];
  kind_t         st_kind_r [0:NS];
  logic [31:0]   st_re_r   [0:NS];
  logic [31:0]   st_im_r   [0:NS];
  logic          st_sat_r  [0:NS];
  logic          st_dz_r   [0:NS];
  logic          st_nre_r  [0:NS];
  logic          st_nim_r  [0:NS];
  logic [63:0]   st_den_r  [0:NS];
  logic [RW-1:0] st_rre_r  [0:NS];
  logic [RW-1:0] st_rim_r  [0:NS];
  logic [32:0]   st_qre_r  [0:NS];
  logic [32:0]   st_qim_r  [0:NS];
  logic [63:0]   st_x_r    [0:NS];
  logic [34:0]   st_srem_r [0:NS];
  logic [31:0]   st_root_r [0:NS];

  // prep: finish add/sub/mul, set up divide and root
  logic signed [64:0] sh_re, sh_im;
  logic [32:0]        c_re, c_im;
  logic [63:0]        mag_re, mag_im;

  assign sh_re  = b0_nre_r >>> FRAC_BITS;
  assign sh_im  = b0_nim_r >>> FRAC_BITS;
  assign mag_re = b0_nre_r[64] ? 64'(-b0_nre_r) : b0_nre_r[63:0];
  assign mag_im = b0_nim_r[64] ? 64'(-b0_nim_r) : b0_nim_r[63:0];

  always_comb begin
    case (b0_kind_r)
      KIND_ADD, KIND_SUB: begin
        c_re = clip65(65'(b0_as_re_r));
        c_im = clip65(65'(b0_as_im_r));
      end
      KIND_MUL: begin
        c_re = clip65(sh_re);
        c_im = clip65(sh_im);
      end
      default: begin
        c_re = '0;
        c_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r[0] <= 1'b0;
    end else if (adv) begin
      st_v_r[0] <= b0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b0_v_r) begin
      st_kind_r[0] <= b0_kind_r;
      st_re_r[0]   <= c_re[31:0];
      st_im_r[0]   <= c_im[31:0];
      st_sat_r[0]  <= c_re[32] || c_im[32];
      st_dz_r[0]   <= (b0_den_r == '0);
      st_nre_r[0]  <= b0_nre_r[64];
      st_nim_r[0]  <= b0_nim_r[64];
      st_den_r[0]  <= b0_den_r;
      st_rre_r[0]  <= RW'(mag_re) << FRAC_BITS;
      st_rim_r[0]  <= RW'(mag_im) << FRAC_BITS;
      st_qre_r[0]  <= '0;
      st_qim_r[0]  <= '0;
      st_x_r[0]    <= b0_den_r;
      st_srem_r[0] <= '0;
      st_root_r[0] <= '0;
    end
  end

  genvar j;
  generate
    for (j = 0; j < NS; j++) begin : g_step
      logic [RW-1:0] dsh;
      logic          ge_re, ge_im;
      logic [34:0]   srem_sh, trial;
      logic          ge_rt;

      // step j weighs quotient bit 32-j
      assign dsh   = RW'(st_den_r[j]) << (QUO_STEPS - 1 - j);
      assign ge_re = (st_rre_r[j] >= dsh);
      assign ge_im = (st_rim_r[j] >= dsh);

      assign srem_sh = {st_srem_r[j][32:0], st_x_r[j][63:62]};
      assign trial   = {1'b0, st_root_r[j], 2'b01};
      assign ge_rt   = (srem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_v_r[j+1] <= 1'b0;
        end else if (adv) begin
          st_v_r[j+1] <= st_v_r[j];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st_kind_r[j+1] <= st_kind_r[j];
          st_re_r[j+1]   <= st_re_r[j];
          st_im_r[j+1]   <= st_im_r[j];
          st_sat_r[j+1]  <= st_sat_r[j];
          st_dz_r[j+1]   <= st_dz_r[j];
          st_nre_r[j+1]  <= st_nre_r[j];
          st_nim_r[j+1]  <= st_nim_r[j];
          st_den_r[j+1]  <= st_den_r[j];
          st_rre_r[j+1]  <= ge_re ? st_rre_r[j] - dsh : st_rre_r[j];
          st_rim_r[j+1]  <= ge_im ? st_rim_r[j] - dsh : st_rim_r[j];
          st_qre_r[j+1]  <= {st_qre_r[j][31:0], ge_re};
          st_qim_r[j+1]  <= {st_qim_r[j][31:0], ge_im};
          if (j < ROOT_STEPS) begin
            st_x_r[j+1]    <= {st_x_r[j][61:0], 2'b00};
            st_srem_r[j+1] <= ge_rt ? srem_sh - trial : srem_sh;
            st_root_r[j+1] <= {st_root_r[j][30:0], ge_rt};
          end else begin
            st_x_r[j+1]    <= st_x_r[j];
            st_srem_r[j+1] <= st_srem_r[j];
            st_root_r[j+1] <= st_root_r[j];
          end
        end
      end
    end
  endgenerate

  // final selection into the output register
  logic [32:0] d_re, d_im;
  logic [31:0] f_re, f_im;
  logic [1:0]  f_st;
  logic        f_sat;

  assign d_re = quo_out(st_nre_r[NS], st_qre_r[NS]);
  assign d_im = quo_out(st_nim_r[NS], st_qim_r[NS]);

  always_comb begin
    f_re  = st_re_r[NS];
    f_im  = st_im_r[NS];
    f_sat = st_sat_r[NS];
    f_st  = ST_OK;
    case (st_kind_r[NS])
      KIND_DIV: begin
        f_re  = st_dz_r[NS] ? 32'd0 : d_re[31:0];
        f_im  = st_dz_r[NS] ? 32'd0 : d_im[31:0];
        f_sat = !st_dz_r[NS] && (d_re[32] || d_im[32]);
      end
      KIND_MAG: begin
        f_sat = st_root_r[NS][31];
        f_re  = f_sat ? 32'h7FFF_FFFF : st_root_r[NS];
        f_im  = 32'd0;
      end
      KIND_NOP: begin
        f_re  = 32'd0;
        f_im  = 32'd0;
        f_sat = 1'b0;
      end
      default: ;
    endcase
    if (st_kind_r[NS] == KIND_DIV && st_dz_r[NS]) begin
      f_st = ST_DZ;
    end else if (f_sat) begin
      f_st = ST_SAT;
    end
  end

  logic        out_v_r;
  logic [31:0] out_re_r, out_im_r;
  logic [1:0]  out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= st_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_v_r[NS]) begin
      out_re_r <= f_re;
      out_im_r <= f_im;
      out_st_r <= f_st;
    end
  end

  assign out_valid = out_v_r;
  assign out_real  = out_re_r;
  assign out_imag  = out_im_r;
  assign status    = out_st_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_st_r == ST_DZ |-> out_re_r == '0 && out_im_r == '0)
    else $error("divide by zero result not cleared");
  a_st_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_st_r != 2'd3) else $error("undefined status code");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> st_v_r[NS] == $past(st_v_r[NS]) && b0_v_r == $past(b0_v_r))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

>>> rtl/complex_arith_unit.sv
// Top level of the complex arithmetic unit.
`default_nettype none
// Complex add, subtract, multiply, divide and magnitude in signed fixed point with
// FRAC_BITS fraction bits. One item is accepted per clock cycle while out_tready does
// not hold the back end; every result passes through the 33-step restoring divider
// pipeline (the 32-step square-root pipeline runs beside it).
// The front end forms all 32x32 products, a FIFO_DEPTH-entry queue decouples it
// from the back end, and the back end stalls as a whole only on out_tready.
// Saturated parts give status 1; a divide by 0+0i gives 0+0i and status 2;
// action codes 5 to 7 give 0+0i with status 0.
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int FIFO_DEPTH = 4
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // left_real, left_imag, right_real, right_imag
  input  wire  [2:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [63:0]  out_tdata,  // out_real, out_imag
  output logic [1:0]   out_tuser   // status
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;
  logic [31:0] res_re, res_im;

  cau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .action     (in_tuser),
    .left_real  ($signed(in_tdata[31:0])),
    .left_imag  ($signed(in_tdata[63:32])),
    .right_real ($signed(in_tdata[95:64])),
    .right_imag ($signed(in_tdata[127:96])),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  cau_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_entry),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_entry)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_real  (res_re),
    .out_imag  (res_im),
    .status    (out_tuser)
  );

  assign out_tdata = {res_im, res_re};

endmodule
`default_nettype wire

>>> dv/tb_complex_arith_unit.sv
// Testbench of the complex arithmetic unit: random and corner operands checked against a predictor.
module tb_complex_arith_unit import cau_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] lr, li, rr, ri;
  } op_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic [1:0]         status;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;

  op_t pending_ops[$];
  res_t expected_results[$];
  bit stim_done = 1'b0;
  bit calm = 1'b0;  // long stretch with no idling
  int errors = 0;
  int cycles = 0;

  complex_arith_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // truncate toward zero: |n| * 2^FRAC / d with sign of n
  function automatic logic signed [31:0] div_trunc(input logic signed [127:0] n,
                                                   input logic signed [127:0] d, ref bit sat);
    logic signed [127:0] mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag <<< FRAC) / d;
    return sat32((n < 0) ? -q : q, sat);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= x) r = b;
    end
    return r;
  endfunction

  function automatic res_t compute_result(input op_t op);
    res_t r;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, d;
    logic [63:0] m;
    r = '{0, 0, ST_OK};
    sat = 1'b0;
    ar = op.lr; ai = op.li; br = op.rr; bi = op.ri;
    case (op.action)
      ACT_ADD: begin
        r.re = sat32(ar + br, sat);
        r.im = sat32(ai + bi, sat);
      end
      ACT_SUB: begin
        r.re = sat32(ar - br, sat);
        r.im = sat32(ai - bi, sat);
      end
      ACT_MUL: begin
        r.re = sat32((ar * br - ai * bi) >>> FRAC, sat);
        r.im = sat32((ai * br + ar * bi) >>> FRAC, sat);
      end
      ACT_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) r.status = ST_DZ;
        else begin
          r.re = div_trunc(ar * br + ai * bi, d, sat);
          r.im = div_trunc(ai * br - ar * bi, d, sat);
        end
      end
      ACT_MAG: begin
        m = root64(64'(ar * ar + ai * ai));
        if (m > 64'h7fffffff) begin
          sat = 1'b1;
          m = 64'h7fffffff;
        end
        r.re = m[31:0];
      end
      default: ;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 8)) - 4;
      4, 5: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    op_t op;
    logic signed [31:0] corner[4];
    corner = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000};
    for (int a = 0; a < 8; a++) begin
      op = '{a[2:0], corner[a % 4], corner[(a + 1) % 4], corner[(a + 2) % 4], corner[(a + 3) % 4]};
      pending_ops.push_back(op);
    end
    // divide by zero, full-scale magnitude, full-scale products, quotients, sums and differences
    pending_ops.push_back(op_t'{ACT_DIV, 32'sh00030000, -32'sh00020000, 0, 0});
    pending_ops.push_back(op_t'{ACT_DIV, 32'sh80000000, 32'sh80000000, 1, 0});
    pending_ops.push_back(op_t'{ACT_MAG, 32'sh80000000, 32'sh80000000, 0, 0});
    pending_ops.push_back(op_t'{ACT_MAG, 32'sh7fffffff, 0, 0, 0});
    pending_ops.push_back(op_t'{ACT_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'sh7fffffff});
    pending_ops.push_back(op_t'{ACT_MUL, -1, 0, 1, 0});
    pending_ops.push_back(op_t'{ACT_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                32'sh7fffffff});
    pending_ops.push_back(op_t'{ACT_SUB, 32'sh80000000, 32'sh7fffffff, 1, -1});
    pending_ops.push_back(op_t'{ACT_ADD, 32'sh7fffffff, 32'sh80000000, 1, -1});
    for (int n = 0; n < 600; n++) begin
      op.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
      op.lr = pick_operand();
      op.li = pick_operand();
      op.rr = pick_operand();
      op.ri = pick_operand();
      pending_ops.push_back(op);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 2) rst_n <= 1'b1;
    calm <= (cycles >= 300) && (cycles < 600);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_complex_arith_unit NOT OK");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    op_t op;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        op = pending_ops.pop_front();
        expected_results.push_back(compute_result(op));
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_ops.size() > (in_tvalid && in_tready ? 0 : 0) &&
            !(in_tvalid && in_tready && pending_ops.size() == 0) &&
            (calm || $urandom_range(0, 99) >= 34)) begin
          op = pending_ops[0];
          in_tvalid <= 1'b1;
          in_tdata <= {op.ri, op.rr, op.li, op.lr};
          in_tuser <= op.action;
        end else begin
          in_tvalid <= 1'b0;
          if (pending_ops.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n) begin
      out_tready <= calm || $urandom_range(0, 99) >= 34;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item pending: %h %h", out_tdata, out_tuser);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata[31:0] !== exp_r.re) begin
            $error("out_real expected %h actual %h", exp_r.re, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== exp_r.im) begin
            $error("out_imag expected %h actual %h", exp_r.im, out_tdata[63:32]);
            errors++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_complex_arith_unit OK");
    end else begin
      $display("tb_complex_arith_unit NOT OK");
    end
    $finish;
  end
endmodule

>>> complex_arith_unit.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_fifo.sv
rtl/cau_back.sv
rtl/complex_arith_unit.sv
dv/tb_complex_arith_unit.sv
